FILE: rtl/core/bpfr_pkg.sv
// Shared types and codes for the buffer pool free ring.
// No dependencies; every file but the two interface files imports this package.
`default_nettype none

package bpfr_pkg;

  // Request operation codes
  typedef enum logic [1:0] {
    OP_INIT = 2'd0,
    OP_GET  = 2'd1,
    OP_PUT  = 2'd2
  } op_t;

  // Result status codes
  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_RANGE     = 3'd1;
  localparam logic [2:0] STAT_FULL      = 3'd2;
  localparam logic [2:0] STAT_EMPTY     = 3'd3;
  localparam logic [2:0] STAT_UNALIGNED = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] REG_BUFFER_SIZE  = 2'd0;
  localparam logic [1:0] REG_BUFFER_COUNT = 2'd1;
  localparam logic [1:0] REG_PAGE_OFFSET  = 2'd2;

  localparam logic [16:0] BUFFER_SIZE_RST  = 17'd2048;
  localparam logic [10:0] BUFFER_COUNT_RST = 11'd512;
  localparam logic [11:0] PAGE_OFFSET_RST  = 12'd0;

  typedef struct packed {
    logic [16:0] buffer_size;
    logic [10:0] buffer_count;
    logic [11:0] page_offset;
  } cfg_t;

  // Request into the serial remainder unit
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
  } rem_req_t;

  // Answer from the serial remainder unit
  typedef struct packed {
    logic        done;
    logic [16:0] rem;
  } rem_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT_FILL,
    ST_GET_RD,
    ST_GET_CHK,
    ST_GET_REM,
    ST_PUT_MUL,
    ST_PUT_CHK,
    ST_PUT_REM,
    ST_RESP
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/core/bpfr_req_if.sv
// Request channel of the buffer pool free ring: operation and put address.
// Standalone; carries valid/ready handshake and payload.
`default_nettype none

interface bpfr_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] buffer_address;

  modport source (output valid, output op, output buffer_address, input ready);
  modport sink   (input valid, input op, input buffer_address, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/bpfr_rsp_if.sv
// Result channel of the buffer pool free ring: status and buffer offset.
// Standalone; carries valid/ready handshake and payload.
`default_nettype none

interface bpfr_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] buffer_offset;

  modport source (output valid, output status, output buffer_offset, input ready);
  modport sink   (input valid, input status, input buffer_offset, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/buffer_pool_free_ring.sv
// Top level of the buffer pool free ring: configuration registers and APB port.
// Depends on bpfr_pkg, bpfr_req_if, bpfr_rsp_if and bpfr_ctrl.
//
//   channel  dir  handshake              payload
//   req      in   valid/ready            op, buffer_address
//   rsp      out  valid/ready            status, buffer_offset
//   apb      in   psel/penable/pready    paddr, pwdata, prdata
//
// One request at a time; ready only while idle. A get or put that reaches
// the remainder step waits on the 32-step serial remainder unit; an empty
// ring, a zero buffer size, an out-of-range address or a full ring return
// sooner. Init writes min(buffer_count, RING_DEPTH) ring entries, one ring
// write per cycle. A result holds in its output register until taken, and
// the next request is accepted the cycle after. Reset is synchronous, empties
// the ring indexes and loads the register defaults; ring contents need no
// clearing.
`default_nettype none

module buffer_pool_free_ring #(
  parameter int RING_DEPTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  bpfr_req_if.sink         req,
  bpfr_rsp_if.source       rsp,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  import bpfr_pkg::*;

  cfg_t cfg;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.buffer_size  <= BUFFER_SIZE_RST;
      cfg.buffer_count <= BUFFER_COUNT_RST;
      cfg.page_offset  <= PAGE_OFFSET_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_BUFFER_SIZE:  cfg.buffer_size  <= pwdata[16:0];
        REG_BUFFER_COUNT: cfg.buffer_count <= pwdata[10:0];
        REG_PAGE_OFFSET:  cfg.page_offset  <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_BUFFER_SIZE:  prdata = 32'(cfg.buffer_size);
      REG_BUFFER_COUNT: prdata = 32'(cfg.buffer_count);
      REG_PAGE_OFFSET:  prdata = 32'(cfg.page_offset);
      default:          prdata = '0;
    endcase
  end

  bpfr_ctrl #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ctrl (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .req (req),
    .rsp (rsp)
  );

endmodule

`default_nettype wire

FILE: rtl/core/bpfr_rem.sv
// Bit-serial restoring remainder unit: 32-bit dividend modulo 17-bit divisor.
// Depends on bpfr_pkg; one dividend bit per cycle, done pulses once the last bit is in.
`default_nettype none

module bpfr_rem (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [16:0]       divisor,
  input  wire bpfr_pkg::rem_req_t req,
  output bpfr_pkg::rem_rsp_t     rsp
);
  import bpfr_pkg::*;

  logic        busy;
  logic        done;
  logic [4:0]  cnt;
  logic [31:0] dvd;
  logic [17:0] r;
  logic [17:0] trial;

  assign trial = {r[16:0], dvd[31]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      r   <= '0;
    end else if (busy) begin
      dvd <= {dvd[30:0], 1'b0};
      // subtract when the shifted partial remainder covers the divisor
      if (trial >= {1'b0, divisor}) begin
        r <= trial - {1'b0, divisor};
      end else begin
        r <= trial;
      end
    end
  end

  assign rsp.done = done;
  assign rsp.rem  = r[16:0];

endmodule

`default_nettype wire

FILE: rtl/core/bpfr_ctrl.sv
// Sequencer, offset ring memory and ring indexes of the buffer pool.
// Depends on bpfr_pkg, bpfr_req_if, bpfr_rsp_if and bpfr_rem.
`default_nettype none

module bpfr_ctrl #(
  parameter int RING_DEPTH = 1024
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire bpfr_pkg::cfg_t cfg,
  bpfr_req_if.sink          req,
  bpfr_rsp_if.source        rsp
);
  import bpfr_pkg::*;

  localparam int IW   = $clog2(RING_DEPTH);
  localparam int CNTW = IW + 1;
  localparam logic [31:0] DEPTH32 = 32'(RING_DEPTH);

  state_t state, state_next;

  logic [31:0] ring [RING_DEPTH];
  logic [31:0] rd_data;
  logic        mem_we;
  logic [IW-1:0] mem_waddr;
  logic [31:0] mem_wdata;

  logic [IW-1:0]   read_index;
  logic [IW-1:0]   write_index;
  logic [CNTW-1:0] fill_cnt;
  logic [CNTW-1:0] fill_n;
  logic [31:0]     fill_val;
  logic [31:0]     addr_q;
  logic [31:0]     off_q;
  logic [27:0]     pool_bytes;
  logic [2:0]      status_q;
  logic [31:0]     offset_q;

  logic        accept;
  logic        ring_empty;
  logic        ring_full;
  logic        fill_done;
  logic        out_of_range;
  logic [31:0] bc32;
  logic [31:0] fill_n32;
  logic [31:0] get_off;
  logic [31:0] put_off;
  rem_req_t    rem_req;
  rem_rsp_t    rem_rsp;

  bpfr_rem u_rem (
    .clk     (clk),
    .rst     (rst),
    .divisor (cfg.buffer_size),
    .req     (rem_req),
    .rsp     (rem_rsp)
  );

  assign accept       = req.valid & req.ready;
  assign ring_empty   = (read_index == write_index);
  assign ring_full    = (IW'(write_index + 1'b1) == read_index);
  assign fill_done    = (fill_cnt == fill_n);
  assign out_of_range = (addr_q >= {4'd0, pool_bytes});
  assign bc32         = 32'(cfg.buffer_count);
  assign fill_n32     = (bc32 > DEPTH32) ? DEPTH32 : bc32;
  assign get_off      = rd_data - 32'(cfg.page_offset);
  assign put_off      = addr_q - 32'(rem_rsp.rem) + 32'(cfg.page_offset);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (req.op)
            OP_INIT: state_next = ST_INIT_FILL;
            OP_GET:  state_next = ring_empty ? ST_RESP : ST_GET_RD;
            OP_PUT:  state_next = ST_PUT_MUL;
            default: state_next = ST_RESP;
          endcase
        end
      end
      ST_INIT_FILL: if (fill_done) state_next = ST_RESP;
      ST_GET_RD:    state_next = ST_GET_CHK;
      ST_GET_CHK:   state_next = (cfg.buffer_size == '0) ? ST_RESP : ST_GET_REM;
      ST_GET_REM:   if (rem_rsp.done) state_next = ST_RESP;
      ST_PUT_MUL:   state_next = ST_PUT_CHK;
      ST_PUT_CHK:   state_next = (out_of_range || ring_full) ? ST_RESP : ST_PUT_REM;
      ST_PUT_REM:   if (rem_rsp.done) state_next = ST_RESP;
      ST_RESP:      if (rsp.ready) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    req.ready        = 1'b0;
    rsp.valid        = 1'b0;
    rem_req.start    = 1'b0;
    rem_req.dividend = addr_q;
    mem_we           = 1'b0;
    mem_waddr        = write_index;
    mem_wdata        = put_off;
    case (state)
      ST_IDLE: req.ready = 1'b1;
      ST_INIT_FILL: begin
        mem_we    = ~fill_done;
        mem_waddr = fill_cnt[IW-1:0];
        mem_wdata = fill_val;
      end
      ST_GET_CHK: begin
        rem_req.start    = (cfg.buffer_size != '0);
        rem_req.dividend = get_off;
      end
      ST_PUT_CHK: rem_req.start = ~out_of_range & ~ring_full;
      ST_PUT_REM: mem_we = rem_rsp.done;
      ST_RESP:    rsp.valid = 1'b1;
      default: ;
    endcase
  end

  assign rsp.status        = status_q;
  assign rsp.buffer_offset = offset_q;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring[mem_waddr] <= mem_wdata;
    end
    rd_data <= ring[read_index];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      read_index  <= '0;
      write_index <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_INIT_FILL: begin
          if (fill_done) begin
            read_index  <= '0;
            write_index <= (fill_n == '0) ? '0 : IW'(fill_n - 1'b1);
          end
        end
        ST_GET_RD:  read_index <= IW'(read_index + 1'b1);
        ST_PUT_REM: if (rem_rsp.done) write_index <= IW'(write_index + 1'b1);
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          addr_q   <= req.buffer_address;
          status_q <= (req.op == OP_GET && ring_empty) ? STAT_EMPTY : STAT_OK;
          offset_q <= '0;
          fill_cnt <= '0;
          fill_n   <= CNTW'(fill_n32);
          fill_val <= 32'(cfg.page_offset);
        end
      end
      ST_INIT_FILL: begin
        if (!fill_done) begin
          fill_cnt <= fill_cnt + 1'b1;
          fill_val <= fill_val + 32'(cfg.buffer_size);
        end
      end
      ST_GET_CHK: begin
        off_q <= get_off;
        if (cfg.buffer_size == '0) offset_q <= get_off;
      end
      ST_GET_REM: begin
        if (rem_rsp.done) begin
          if (rem_rsp.rem != '0) status_q <= STAT_UNALIGNED;
          else offset_q <= off_q;
        end
      end
      ST_PUT_MUL: pool_bytes <= 28'(cfg.buffer_count) * 28'(cfg.buffer_size);
      ST_PUT_CHK: begin
        if (out_of_range) status_q <= STAT_RANGE;
        else if (ring_full) status_q <= STAT_FULL;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: tb/tb_buffer_pool_free_ring.sv
// Self-checking testbench for buffer_pool_free_ring: drives requests and APB writes,
// predicts every status and buffer offset, and compares each result in order.
// Depends on bpfr_pkg, bpfr_req_if, bpfr_rsp_if and the buffer_pool_free_ring RTL.
`default_nettype none

module tb_buffer_pool_free_ring;
  timeunit 1ns;
  timeprecision 1ps;

  import bpfr_pkg::*;

  localparam int DEPTH = 1024;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int PHASES = 12;
  localparam int PHASE_REQUESTS = 150;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] buffer_offset;
  } outcome_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bpfr_req_if req_ch ();
  bpfr_rsp_if rsp_ch ();

  buffer_pool_free_ring #(.RING_DEPTH(DEPTH)) dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow of the pool: ring contents, indexes and register values
  logic [31:0] ring_shadow [DEPTH];
  logic [9:0]  rd_ptr;
  logic [9:0]  wr_ptr;
  cfg_t        pool_cfg;

  outcome_t pending_outcomes [$];
  int       mismatch_count;
  int       requests_accepted;
  int       settings_applied;
  int       status_seen [8];
  bit       sender_gaps;
  bit       receiver_gaps;
  int       rsp_hold_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("%0t: timeout, %0d results still outstanding", $time, pending_outcomes.size());
    $display("tb_buffer_pool_free_ring: done, errors");
    $finish;
  end

  // Work out the result of one request and update the shadow pool
  function automatic outcome_t predict_pool_op(input logic [1:0] op, input logic [31:0] addr);
    outcome_t         res;
    longint unsigned  pool_bytes;
    logic [31:0]      entry;
    logic [31:0]      offs;
    logic [31:0]      fill;
    logic [9:0]       next_wr;
    int               n;
    res.status = STAT_OK;
    res.buffer_offset = '0;
    case (op)
      OP_INIT: begin
        n = int'(pool_cfg.buffer_count);
        if (n > DEPTH) n = DEPTH;
        fill = 32'(pool_cfg.page_offset);
        for (int i = 0; i < n; i++) begin
          ring_shadow[i] = fill;
          fill = fill + 32'(pool_cfg.buffer_size);
        end
        rd_ptr = '0;
        wr_ptr = (n == 0) ? '0 : 10'(n - 1);
      end
      OP_GET: begin
        if (rd_ptr == wr_ptr) begin
          res.status = STAT_EMPTY;
        end else begin
          entry = ring_shadow[rd_ptr];
          rd_ptr = rd_ptr + 10'd1;
          offs = entry - 32'(pool_cfg.page_offset);
          if (pool_cfg.buffer_size != 0 && (offs % 32'(pool_cfg.buffer_size)) != 0)
            res.status = STAT_UNALIGNED;
          else
            res.buffer_offset = offs;
        end
      end
      OP_PUT: begin
        pool_bytes = 64'(pool_cfg.buffer_count);
        pool_bytes = pool_bytes * 64'(pool_cfg.buffer_size);
        if (64'(addr) >= pool_bytes) begin
          res.status = STAT_RANGE;
        end else begin
          offs = addr - (addr % 32'(pool_cfg.buffer_size)) + 32'(pool_cfg.page_offset);
          next_wr = wr_ptr + 10'd1;
          if (next_wr == rd_ptr) begin
            res.status = STAT_FULL;
          end else begin
            ring_shadow[wr_ptr] = offs;
            wr_ptr = next_wr;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Results are matched first: one returned at this edge belongs to an earlier request
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t: result with nothing outstanding: status %0d offset %h", $time,
                 rsp_ch.status, rsp_ch.buffer_offset);
        mismatch_count++;
      end else begin
        want = pending_outcomes.pop_front();
        status_seen[rsp_ch.status]++;
        if (rsp_ch.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_ch.status);
          mismatch_count++;
        end
        if (rsp_ch.buffer_offset !== want.buffer_offset) begin
          $display("%0t: buffer_offset expected %h actual %h", $time, want.buffer_offset,
                   rsp_ch.buffer_offset);
          mismatch_count++;
        end
      end
    end
    if (!rst && req_ch.valid && req_ch.ready) begin
      pending_outcomes.push_back(predict_pool_op(req_ch.op, req_ch.buffer_address));
      requests_accepted++;
    end
  end

  // Result side: long hold on demand, otherwise random stall bursts while receiver_gaps is set
  initial begin
    rsp_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (rsp_hold_cycles > 0) begin
        rsp_ch.ready = 1'b0;
        repeat (rsp_hold_cycles) @(negedge clk);
        rsp_hold_cycles = 0;
      end else if (receiver_gaps && $urandom_range(0, 3) == 0) begin
        rsp_ch.ready = 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end else begin
        rsp_ch.ready = 1'b1;
        @(negedge clk);
      end
    end
  end

  // Called at a falling edge; returns at a falling edge
  task automatic send_request(input logic [1:0] op, input logic [31:0] addr);
    req_ch.valid = 1'b1;
    req_ch.op = op;
    req_ch.buffer_address = addr;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
    req_ch.valid = 1'b0;
    if (sender_gaps && $urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 12)) @(negedge clk);
  endtask

  task automatic wait_for_results();
    while (pending_outcomes.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    case (idx)
      REG_BUFFER_SIZE:  pool_cfg.buffer_size = value[16:0];
      REG_BUFFER_COUNT: pool_cfg.buffer_count = value[10:0];
      REG_PAGE_OFFSET:  pool_cfg.page_offset = value[11:0];
      default: ;
    endcase
  endtask

  task automatic set_pool(input logic [16:0] size, input logic [10:0] count,
                          input logic [11:0] page);
    wait_for_results();
    write_register(REG_BUFFER_SIZE, 32'(size));
    write_register(REG_BUFFER_COUNT, 32'(count));
    write_register(REG_PAGE_OFFSET, 32'(page));
    settings_applied++;
  endtask

  // Mostly gets and in-range puts; the rest is noise
  task automatic random_request();
    int              pick;
    longint unsigned pool_bytes;
    logic [31:0]     addr;
    pick = $urandom_range(0, 99);
    pool_bytes = 64'(pool_cfg.buffer_count);
    pool_bytes = pool_bytes * 64'(pool_cfg.buffer_size);
    if (pick < 45) begin
      send_request(OP_GET, $urandom);
    end else if (pick < 85) begin
      if (pool_bytes == 0)
        addr = $urandom;
      else if ($urandom_range(0, 7) == 0)
        addr = 32'(pool_bytes - 1);
      else
        addr = $urandom_range(0, 32'(pool_bytes - 1));
      send_request(OP_PUT, addr);
    end else if (pick < 93) begin
      send_request(OP_PUT, $urandom);
    end else if (pick < 96) begin
      send_request(OP_UNUSED, $urandom);
    end else begin
      send_request(OP_INIT, $urandom);
    end
  endtask

  task automatic apply_reset();
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.op = OP_INIT;
    req_ch.buffer_address = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rd_ptr = '0;
    wr_ptr = '0;
    pool_cfg.buffer_size = BUFFER_SIZE_RST;
    pool_cfg.buffer_count = BUFFER_COUNT_RST;
    pool_cfg.page_offset = PAGE_OFFSET_RST;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);
  endtask

  // Register defaults: empty ring, unused op, put before any init, init, pool bounds
  task automatic test_reset_defaults();
    send_request(OP_GET, 32'd0);
    send_request(OP_UNUSED, 32'hFFFF_FFFF);
    send_request(OP_PUT, 32'd0);
    send_request(OP_GET, 32'd0);
    send_request(OP_INIT, 32'd0);
    send_request(OP_GET, 32'd0);
    send_request(OP_GET, 32'd0);
    send_request(OP_PUT, 32'd4097);
    send_request(OP_PUT, 32'd512 * 32'd2048 - 32'd1);
    send_request(OP_PUT, 32'd512 * 32'd2048);
    send_request(OP_PUT, 32'hFFFF_FFFF);
  endtask

  // Zero size and count, then every register at its top value
  task automatic test_register_limits();
    set_pool(17'd0, 11'd0, 12'd4095);
    send_request(OP_INIT, 32'd0);
    send_request(OP_GET, 32'd0);
    send_request(OP_PUT, 32'd0);
    set_pool(17'h1FFFF, 11'h7FF, 12'd4095);
    send_request(OP_INIT, 32'd0);
    send_request(OP_PUT, 32'd0);
    send_request(OP_GET, 32'd0);
    send_request(OP_GET, 32'd0);
    send_request(OP_PUT, 32'd2047 * 32'h1FFFF - 32'd1);
    send_request(OP_PUT, 32'd2047 * 32'h1FFFF);
  endtask

  // Raise page_offset above stored entries: one misaligned pop, one wrapped offset
  task automatic test_offset_wrap();
    set_pool(17'd1, 11'd2, 12'd0);
    send_request(OP_INIT, 32'd0);
    send_request(OP_PUT, 32'd1);
    set_pool(17'd2048, 11'd2, 12'd4095);
    send_request(OP_GET, 32'd0);
    set_pool(17'd1, 11'd2, 12'd4095);
    send_request(OP_GET, 32'd0);
  endtask

  task automatic test_random_phases();
    logic [16:0] size;
    logic [10:0] count;
    logic [11:0] page;
    for (int p = 0; p < PHASES; p++) begin
      case ($urandom_range(0, 5))
        0:       size = 17'd1;
        1:       size = 17'd65536;
        2:       size = 17'h1FFFF;
        3:       size = 17'd1 << $urandom_range(0, 16);
        default: size = 17'($urandom_range(1, 4096));
      endcase
      case ($urandom_range(0, 7))
        0:       count = 11'($urandom_range(0, 3));
        1, 2:    count = 11'($urandom_range(1, 16));
        3:       count = 11'd1024;
        4:       count = 11'($urandom_range(1025, 2047));
        default: count = 11'($urandom_range(17, 1023));
      endcase
      case ($urandom_range(0, 3))
        0:       page = 12'd0;
        1:       page = 12'd4095;
        default: page = 12'($urandom_range(0, 4095));
      endcase
      set_pool(size, count, page);
      // keep the old ring now and then so stale entries meet the new layout
      if ($urandom_range(0, 2) != 0)
        send_request(OP_INIT, $urandom);
      repeat (PHASE_REQUESTS) random_request();
    end
  endtask

  // Hold the result side while requests keep coming, so the input stalls
  task automatic test_result_backpressure();
    set_pool(17'd256, 11'd32, 12'd12);
    send_request(OP_INIT, 32'd0);
    sender_gaps = 1'b0;
    rsp_hold_cycles = 300;
    for (int i = 0; i < 16; i++)
      send_request((i % 2 == 0) ? OP_PUT : OP_GET, $urandom_range(0, 32 * 256 - 1));
    sender_gaps = 1'b1;
  endtask

  task automatic test_steady_stream();
    wait_for_results();
    sender_gaps = 1'b0;
    receiver_gaps = 1'b0;
    set_pool(17'd64, 11'd24, 12'd100);
    send_request(OP_INIT, 32'd0);
    repeat (110) random_request();
  endtask

  initial begin
    int guard;
    mismatch_count = 0;
    requests_accepted = 0;
    settings_applied = 0;
    rsp_hold_cycles = 0;
    sender_gaps = 1'b1;
    receiver_gaps = 1'b1;
    foreach (status_seen[i]) status_seen[i] = 0;
    apply_reset();

    test_reset_defaults();
    test_register_limits();
    test_offset_wrap();
    test_random_phases();
    test_result_backpressure();
    test_steady_stream();

    guard = 0;
    while (pending_outcomes.size() != 0 && guard < 5000) begin
      @(negedge clk);
      guard++;
    end
    repeat (40) @(negedge clk);
    if (pending_outcomes.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_outcomes.size());
      mismatch_count += pending_outcomes.size();
    end

    $display("covered %0d requests over %0d pool settings, with a held result side",
             requests_accepted, settings_applied);
    $display("results: %0d ok, %0d out of range, %0d full, %0d empty, %0d misaligned",
             status_seen[STAT_OK], status_seen[STAT_RANGE], status_seen[STAT_FULL],
             status_seen[STAT_EMPTY], status_seen[STAT_UNALIGNED]);
    if (mismatch_count == 0) begin
      $display("tb_buffer_pool_free_ring: done, clean");
    end else begin
      $display("tb_buffer_pool_free_ring: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/core/bpfr_pkg.sv
rtl/core/bpfr_req_if.sv
rtl/core/bpfr_rsp_if.sv
rtl/core/bpfr_rem.sv
rtl/core/bpfr_ctrl.sv
rtl/core/buffer_pool_free_ring.sv
tb/tb_buffer_pool_free_ring.sv
